// ===== rtl/core/mcpg_pkg.sv =====
// Shared types and constants of the midpoint circle point generator.
package mcpg_pkg;

   localparam int COORD_BITS    = 16;
   localparam int COLOR_BITS    = 16;
   localparam int DEC_BITS      = 18;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int QUEUE_DEPTH   = 2;

   // Decision update constants of the midpoint scheme.
   localparam int DEC_INIT     = 3;
   localparam int DEC_STEP_NEG = 6;
   localparam int DEC_STEP_POS = 10;

   // Request operation codes.
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // Register word index (byte address bit 2).
   localparam logic REG_DRAW_COLOR = 1'b0;

   // Mirrored point order within one iteration.
   typedef enum logic [2:0] {
      OCT_PX_PY = 3'd0,
      OCT_PX_NY = 3'd1,
      OCT_NX_PY = 3'd2,
      OCT_NX_NY = 3'd3,
      OCT_PY_PX = 3'd4,
      OCT_PY_NX = 3'd5,
      OCT_NY_PX = 3'd6,
      OCT_NY_NX = 3'd7
   } octant_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/core/mcpg_front.sv =====
// Front end: accepts requests, keeps the circle state and queues one record per iteration.
module mcpg_front #(
   parameter int RADIUS_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             op,
   input  logic [mcpg_pkg::COORD_BITS-1:0]  center_x,
   input  logic [mcpg_pkg::COORD_BITS-1:0]  center_y,
   input  logic [11:0]                      radius,
   output logic                             q_push,
   output logic [2*mcpg_pkg::COORD_BITS+2*RADIUS_BITS:0] q_data
);
   import mcpg_pkg::*;

   logic [COORD_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [RADIUS_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [DEC_BITS-1:0]    d_ff, d_in;
   logic                   active_ff, active_in;

   logic                   start;
   logic [RADIUS_BITS-1:0] r, x_cur, y_cur;
   logic [COORD_BITS-1:0]  cx_cur, cy_cur;
   logic [DEC_BITS-1:0]    d_cur, xe, ye;
   logic                   neg, done;
   logic signed [RADIUS_BITS+1:0] nx, ny;

   always_comb begin
      start  = (op == OP_START);
      r      = RADIUS_BITS'(radius);
      cx_cur = start ? center_x : cx_ff;
      cy_cur = start ? center_y : cy_ff;
      x_cur  = start ? '0 : x_ff;
      y_cur  = start ? r : y_ff;
      d_cur  = start ? (DEC_BITS'(DEC_INIT) - (DEC_BITS'(r) << 1)) : d_ff;
      xe     = DEC_BITS'(x_cur);
      ye     = DEC_BITS'(y_cur);
      neg    = d_cur[DEC_BITS-1];
      nx     = $signed({2'b00, x_cur}) + $signed((RADIUS_BITS+2)'(1));
      if (neg) begin
         ny = $signed({2'b00, y_cur});
      end else begin
         ny = $signed({2'b00, y_cur}) - $signed((RADIUS_BITS+2)'(1));
      end
      done   = nx > ny;
      q_push = accept && (start || active_ff);
      q_data = {cx_cur, cy_cur, x_cur, y_cur, done};

      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      active_in = active_ff;
      if (q_push) begin
         cx_in     = cx_cur;
         cy_in     = cy_cur;
         x_in      = nx[RADIUS_BITS-1:0];
         y_in      = ny[RADIUS_BITS-1:0];
         active_in = !done;
         if (neg) begin
            d_in = d_cur + (xe << 2) + DEC_BITS'(DEC_STEP_NEG);
         end else begin
            d_in = d_cur + ((xe - ye) << 2) + DEC_BITS'(DEC_STEP_POS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         d_ff      <= '0;
      end else begin
         active_ff <= active_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         d_ff      <= d_in;
      end
   end

endmodule

// ===== rtl/core/mcpg_queue.sv =====
// Short register queue between the front end and the point emitter.
module mcpg_queue #(
   parameter int WIDTH = 57
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output mcpg_pkg::queue_status_type status
);
   import mcpg_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      pop_data     = entry_ff[rptr_ff];
      wptr_in      = wptr_ff;
      rptr_in      = rptr_ff;
      count_in     = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/mcpg_back.sv =====
// Back end: expands one queued iteration into its eight mirrored points.
module mcpg_back #(
   parameter int RADIUS_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mcpg_pkg::queue_status_type        q_status,
   input  logic [2*mcpg_pkg::COORD_BITS+2*RADIUS_BITS:0] q_data,
   output logic                              q_pop,
   input  logic [mcpg_pkg::COLOR_BITS-1:0]   color,
   input  logic                              pop,
   output logic                              empty,
   output logic [mcpg_pkg::COORD_BITS-1:0]   point_x,
   output logic [mcpg_pkg::COORD_BITS-1:0]   point_y,
   output logic [mcpg_pkg::COLOR_BITS-1:0]   point_color,
   output logic [2:0]                        octant,
   output logic                              last
);
   import mcpg_pkg::*;

   logic [COORD_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [RADIUS_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic                   fin_ff, fin_in;
   logic                   busy_ff, busy_in;
   octant_type             oct_ff, oct_in;
   logic                   finish, load;
   logic [COORD_BITS-1:0]  xe, ye;

   always_comb begin
      finish  = pop && busy_ff && (oct_ff == OCT_NY_NX);
      load    = !q_status.empty && (!busy_ff || finish);
      q_pop   = load;
      busy_in = busy_ff;
      oct_in  = oct_ff;
      {cx_in, cy_in, x_in, y_in, fin_in} = {cx_ff, cy_ff, x_ff, y_ff, fin_ff};
      if (load) begin
         {cx_in, cy_in, x_in, y_in, fin_in} = q_data;
         busy_in = 1'b1;
         oct_in  = OCT_PX_PY;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (pop && busy_ff) begin
         oct_in = octant_type'(oct_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         oct_ff  <= OCT_PX_PY;
      end else begin
         busy_ff <= busy_in;
         oct_ff  <= oct_in;
      end
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      fin_ff <= fin_in;
   end

   always_comb begin
      xe = COORD_BITS'(x_ff);
      ye = COORD_BITS'(y_ff);
      case (oct_ff) inside
         OCT_PX_PY, OCT_PX_NY: point_x = cx_ff + xe;
         OCT_NX_PY, OCT_NX_NY: point_x = cx_ff - xe;
         OCT_PY_PX, OCT_PY_NX: point_x = cx_ff + ye;
         default:              point_x = cx_ff - ye;
      endcase
      case (oct_ff) inside
         OCT_PX_PY, OCT_NX_PY: point_y = cy_ff + ye;
         OCT_PX_NY, OCT_NX_NY: point_y = cy_ff - ye;
         OCT_PY_PX, OCT_NY_PX: point_y = cy_ff + xe;
         default:              point_y = cy_ff - xe;
      endcase
      empty       = !busy_ff;
      point_color = color;
      octant      = oct_ff;
      last        = fin_ff && (oct_ff == OCT_NY_NX);
   end

   // A point that is taken before the eighth advances the octant by one.
   a_oct_step: assert property (@(posedge clock) disable iff (reset)
      (pop && busy_ff && oct_ff != OCT_NY_NX) |=> (busy_ff && oct_ff == $past(oct_ff) + 3'd1))
      else $error("octant did not advance after a point transaction");

   // The iteration record holds while its points are still being delivered.
   a_rec_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !finish) |=> ($stable(cx_ff) && $stable(cy_ff) && $stable(x_ff)
                                && $stable(y_ff) && $stable(fin_ff)))
      else $error("iteration record changed mid-iteration");

   // With nothing queued, finishing an iteration leaves the result side empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (finish && q_status.empty) |=> empty)
      else $error("result side not empty after the last queued iteration");

   // A newly loaded record starts at octant zero.
   a_load_oct: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && oct_ff == OCT_PX_PY))
      else $error("new iteration did not start at the first octant");

endmodule

// ===== rtl/core/midpoint_circle_point_generator.sv =====
// Top level of the midpoint circle point generator: register port, front end, queue, emitter.
//
//  Channel   Handshake            Payload
//  request   push / full          req_op, req_center_x, req_center_y, req_radius
//  response  pop / empty          rsp_point_x, rsp_point_y, rsp_point_color,
//                                 rsp_octant, rsp_last
//  register  psel/penable/pwrite  paddr, pwdata, prdata, pready (always high)
//
// A start or advance transaction is taken by the front end, which updates the circle
// state and queues one iteration record. The emitter turns each record into eight
// points, one per cycle while the response side pops; the two-entry queue lets new
// transactions be taken while earlier records are still being emitted. With the
// pipeline empty, an accepted transaction is registered in the queue and then in the
// emitter's record register before its first point appears. An advance while no
// circle is active is accepted and yields nothing. Reset is synchronous and clears
// the circle state, the queue, the emitter and the color register. A stalled response
// side fills the queue, after which full rises until the emitter frees an entry.
module midpoint_circle_point_generator #(
   parameter int RADIUS_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_op,
   input  logic [mcpg_pkg::COORD_BITS-1:0]      req_center_x,
   input  logic [mcpg_pkg::COORD_BITS-1:0]      req_center_y,
   input  logic [11:0]                          req_radius,

   output logic                                 empty,
   input  logic                                 pop,
   output logic [mcpg_pkg::COORD_BITS-1:0]      rsp_point_x,
   output logic [mcpg_pkg::COORD_BITS-1:0]      rsp_point_y,
   output logic [mcpg_pkg::COLOR_BITS-1:0]      rsp_point_color,
   output logic [2:0]                           rsp_octant,
   output logic                                 rsp_last,

   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mcpg_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [mcpg_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [mcpg_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import mcpg_pkg::*;

   // One queue record: center x, center y, offset x, offset y, final-iteration flag.
   localparam int REC_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  csr_write;
   logic                  accept;
   logic                  q_push, q_pop;
   logic [REC_BITS-1:0]   q_wdata, q_rdata;
   queue_status_type      q_status;

   // The color register is the only register; it sits at byte address zero.
   always_comb begin
      pready    = 1'b1;
      csr_write = psel && penable && pwrite && pready;
      color_in  = color_ff;
      if (csr_write && paddr[2] == REG_DRAW_COLOR) begin
         color_in = pwdata[COLOR_BITS-1:0];
      end
      prdata = '0;
      if (paddr[2] == REG_DRAW_COLOR) begin
         prdata = CSR_DATA_BITS'(color_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
      end else begin
         color_ff <= color_in;
      end
   end

   // The request side stalls only when the iteration queue has no room.
   assign full   = q_status.full;
   assign accept = push && !full;

   mcpg_front #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op       (req_op),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .radius   (req_radius),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   mcpg_queue #(
      .WIDTH (REC_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   mcpg_back #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .color       (color_ff),
      .pop         (pop),
      .empty       (empty),
      .point_x     (rsp_point_x),
      .point_y     (rsp_point_y),
      .point_color (rsp_point_color),
      .octant      (rsp_octant),
      .last        (rsp_last)
   );

endmodule
